/* rtl/occupancy_block_downsampler_top_defines.svh */
// Assertion macros for the occupancy block downsampler.
// Used by the top level only; no other dependencies.
`ifndef OCCUPANCY_BLOCK_DOWNSAMPLER_TOP_DEFINES_SVH
`define OCCUPANCY_BLOCK_DOWNSAMPLER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define OBD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define OBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/obd_pkg.sv */
// Shared widths, types and constants of the occupancy block downsampler.
// No dependencies; imported by the interfaces, the top level, the checker and the testbench.
`default_nettype none

package obd_pkg;

   localparam int CELL_W     = 8;
   localparam int POS_W      = 10;
   localparam int OFS_W      = 4;
   localparam int CNT_W      = 9;
   localparam int DIM_W      = 11;
   localparam int BS_W       = 5;
   localparam int RATIO_W    = 17;
   localparam int CFG_IDX_W  = 3;
   localparam int CFG_DATA_W = 17;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_STRIDE = 16;
   localparam int BS_MAX     = (MAX_STRIDE < 16) ? MAX_STRIDE : 16;
   localparam int RATIO_ONE  = 65536;

   localparam int MEM_W      = 2 * CNT_W;
   localparam int MEM_DEPTH  = 1 << POS_W;

   localparam logic [DIM_W-1:0]   MAP_WIDTH_RST  = DIM_W'(64);
   localparam logic [DIM_W-1:0]   MAP_HEIGHT_RST = DIM_W'(64);
   localparam logic [BS_W-1:0]    BLOCK_SIZE_RST = BS_W'(1);
   localparam logic [CELL_W-1:0]  THRESHOLD_RST  = CELL_W'(0);
   localparam logic [RATIO_W-1:0] RATIO_RST      = RATIO_W'(32768);

   typedef logic signed [CELL_W-1:0] cell_type;
   typedef logic [POS_W-1:0]         pos_type;

   typedef enum logic [CFG_IDX_W-1:0] {
      CFG_MAP_WIDTH  = 3'd0,
      CFG_MAP_HEIGHT = 3'd1,
      CFG_BLOCK_SIZE = 3'd2,
      CFG_THRESHOLD  = 3'd3,
      CFG_FREE_RATIO = 3'd4
   } cfg_index_type;

endpackage

`default_nettype wire

/* rtl/obd_req_if.sv */
// Input channel of the downsampler: one map cell per item.
// Depends on obd_pkg.
`default_nettype none

interface obd_req_if;
   import obd_pkg::*;

   logic     valid;
   logic     ready;
   cell_type cell_value;

   modport source (output valid, output cell_value, input ready);
   modport sink   (input valid, input cell_value, output ready);
endinterface

`default_nettype wire

/* rtl/obd_rsp_if.sv */
// Result channel of the downsampler: one completed block per item.
// Depends on obd_pkg.
`default_nettype none

interface obd_rsp_if;
   import obd_pkg::*;

   logic    valid;
   logic    ready;
   pos_type block_col;
   pos_type block_row;
   logic    is_free;
   logic    last_block;

   modport source (output valid, output block_col, output block_row,
                   output is_free, output last_block, input ready);
   modport sink   (input valid, input block_col, input block_row,
                   input is_free, input last_block, output ready);
endinterface

`default_nettype wire

/* rtl/obd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module obd_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/occupancy_block_downsampler_top.sv */
// Occupancy block downsampler, top level.
// Depends on obd_pkg, obd_req_if, obd_rsp_if, obd_ram and the defines header.
//
// Usage:
//   Map cells enter on req_ch in raster order, one signed byte per item. They
//   are pooled into block_size x block_size blocks; edge blocks may be partial.
//   When the last cell of a block arrives, one item leaves on rsp_ch with the
//   block column and row, the free flag and a flag on the final block of the map.
//   Registers are written on the csr_ port, one per cycle. The user must write
//   them only while the block idles; the block itself does not enforce it.
//   Throughput: one cell per cycle unless req_ch.ready drops. Each cell does one
//   read-modify-write of the per-column count RAM: read at acceptance, write as
//   it leaves stage 1, with a bypass for a cell read while its column is written.
//   Stall: while a result waits on rsp_ch, cells that complete no block still
//   flow; a cell that completes a block holds in the stage and req_ch.ready drops.
//   Reset: registers return to their defaults and the map position to the
//   top-left corner. The count RAM is not cleared; each entry is written by the
//   top-left cell of a block before its value is used.
`default_nettype none
`include "occupancy_block_downsampler_top_defines.svh"

module occupancy_block_downsampler_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [obd_pkg::CFG_IDX_W-1:0]  csr_index,
   input  logic [obd_pkg::CFG_DATA_W-1:0] csr_wr_data,
   obd_req_if.sink                       req_ch,
   obd_rsp_if.source                     rsp_ch
);
   import obd_pkg::*;

   // configuration registers
   logic [DIM_W-1:0]          map_width_ff;
   logic [DIM_W-1:0]          map_height_ff;
   logic [BS_W-1:0]           block_size_ff;
   logic signed [CELL_W-1:0]  threshold_ff;
   logic [RATIO_W-1:0]        ratio_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= MAP_WIDTH_RST;
         map_height_ff <= MAP_HEIGHT_RST;
         block_size_ff <= BLOCK_SIZE_RST;
         threshold_ff  <= THRESHOLD_RST;
         ratio_ff      <= RATIO_RST;
      end else if (csr_wr_en) begin
         case (cfg_index_type'(csr_index))
            CFG_MAP_WIDTH: begin
               map_width_ff <= csr_wr_data[DIM_W-1:0];
            end
            CFG_MAP_HEIGHT: begin
               map_height_ff <= csr_wr_data[DIM_W-1:0];
            end
            CFG_BLOCK_SIZE: begin
               block_size_ff <= csr_wr_data[BS_W-1:0];
            end
            CFG_THRESHOLD: begin
               threshold_ff <= csr_wr_data[CELL_W-1:0];
            end
            CFG_FREE_RATIO: begin
               ratio_ff <= csr_wr_data[RATIO_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // saturated register values
   logic [DIM_W-1:0]   w_c;
   logic [DIM_W-1:0]   h_c;
   logic [BS_W-1:0]    bs_c;
   logic [RATIO_W-1:0] ratio_c;

   always_comb begin
      if (map_width_ff == '0) begin
         w_c = DIM_W'(1);
      end else if (13'(map_width_ff) > 13'(MAX_WIDTH)) begin
         w_c = DIM_W'(MAX_WIDTH);
      end else begin
         w_c = map_width_ff;
      end
      if (map_height_ff == '0) begin
         h_c = DIM_W'(1);
      end else if (13'(map_height_ff) > 13'(MAX_HEIGHT)) begin
         h_c = DIM_W'(MAX_HEIGHT);
      end else begin
         h_c = map_height_ff;
      end
      if (block_size_ff == '0) begin
         bs_c = BS_W'(1);
      end else if (block_size_ff > BS_W'(BS_MAX)) begin
         bs_c = BS_W'(BS_MAX);
      end else begin
         bs_c = block_size_ff;
      end
      ratio_c = (ratio_ff > RATIO_W'(RATIO_ONE)) ? RATIO_W'(RATIO_ONE) : ratio_ff;
   end

   // stream position
   logic [POS_W-1:0] cell_col_ff, cell_col_in;
   logic [POS_W-1:0] cell_row_ff, cell_row_in;
   logic [OFS_W-1:0] ofs_blk_ff, ofs_blk_in;
   logic [OFS_W-1:0] ofs_band_ff, ofs_band_in;
   logic [POS_W-1:0] bcol_ff, bcol_in;
   logic [POS_W-1:0] brow_ff, brow_in;

   logic row_end, col_end, blk_x_step, blk_y_step, blk_x_end, blk_y_end;
   logic first_cell, free_cell, accept;

   // stage 1 and output registers
   logic             s1_valid_ff;
   logic [POS_W-1:0] s1_bc_ff;
   logic [POS_W-1:0] s1_brow_ff;
   logic             s1_first_ff;
   logic             s1_free_ff;
   logic             s1_emit_ff;
   logic             s1_last_ff;
   logic             fwd_hit_ff;
   logic [MEM_W-1:0] fwd_data_ff;
   logic             s1_go;

   logic             rsp_valid_ff;
   logic [POS_W-1:0] rsp_col_ff;
   logic [POS_W-1:0] rsp_row_ff;
   logic             rsp_free_ff;
   logic             rsp_last_ff;
   logic             rsp_load;

   assign accept       = req_ch.valid && req_ch.ready;
   assign s1_go        = !s1_valid_ff || !s1_emit_ff || !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = s1_go;

   always_comb begin
      row_end    = ({1'b0, cell_col_ff} + DIM_W'(1)) >= w_c;
      col_end    = ({1'b0, cell_row_ff} + DIM_W'(1)) >= h_c;
      blk_x_step = ({1'b0, ofs_blk_ff} + BS_W'(1)) >= bs_c;
      blk_y_step = ({1'b0, ofs_band_ff} + BS_W'(1)) >= bs_c;
      blk_x_end  = blk_x_step || row_end;
      blk_y_end  = blk_y_step || col_end;
      first_cell = (ofs_blk_ff == '0) && (ofs_band_ff == '0);
      free_cell  = (req_ch.cell_value >= 8'sd0) && (req_ch.cell_value <= threshold_ff);

      cell_col_in = cell_col_ff;
      cell_row_in = cell_row_ff;
      ofs_blk_in  = ofs_blk_ff;
      ofs_band_in = ofs_band_ff;
      bcol_in     = bcol_ff;
      brow_in     = brow_ff;
      if (row_end) begin
         cell_col_in = '0;
         ofs_blk_in  = '0;
         bcol_in     = '0;
         if (col_end) begin
            cell_row_in = '0;
            ofs_band_in = '0;
            brow_in     = '0;
         end else begin
            cell_row_in = cell_row_ff + POS_W'(1);
            if (blk_y_step) begin
               ofs_band_in = '0;
               brow_in     = brow_ff + POS_W'(1);
            end else begin
               ofs_band_in = ofs_band_ff + OFS_W'(1);
            end
         end
      end else begin
         cell_col_in = cell_col_ff + POS_W'(1);
         if (blk_x_step) begin
            ofs_blk_in = '0;
            bcol_in    = bcol_ff + POS_W'(1);
         end else begin
            ofs_blk_in = ofs_blk_ff + OFS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_col_ff <= '0;
         cell_row_ff <= '0;
         ofs_blk_ff  <= '0;
         ofs_band_ff <= '0;
         bcol_ff     <= '0;
         brow_ff     <= '0;
      end else if (accept) begin
         cell_col_ff <= cell_col_in;
         cell_row_ff <= cell_row_in;
         ofs_blk_ff  <= ofs_blk_in;
         ofs_band_ff <= ofs_band_in;
         bcol_ff     <= bcol_in;
         brow_ff     <= brow_in;
      end
   end

   // count RAM: free count in the upper half, cell count in the lower half
   logic [MEM_W-1:0] ram_rdata;
   logic [MEM_W-1:0] old_data;
   logic [MEM_W-1:0] new_data;
   logic [CNT_W-1:0] new_free;
   logic [CNT_W-1:0] new_cells;
   logic [CNT_W+RATIO_W-1:0] product;
   logic [CNT_W:0]   required;
   logic             blk_free;

   obd_ram #(
      .WIDTH (MEM_W),
      .DEPTH (MEM_DEPTH)
   ) u_counts (
      .clock   (clock),
      .wr_en   (s1_valid_ff && s1_go),
      .wr_addr (s1_bc_ff),
      .wr_data (new_data),
      .rd_en   (accept),
      .rd_addr (bcol_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      // take the bypass when the previous item wrote this column at the read edge
      old_data = fwd_hit_ff ? fwd_data_ff : ram_rdata;
      if (s1_first_ff) begin
         new_free  = {{(CNT_W-1){1'b0}}, s1_free_ff};
         new_cells = CNT_W'(1);
      end else begin
         new_free  = old_data[MEM_W-1:CNT_W] + {{(CNT_W-1){1'b0}}, s1_free_ff};
         new_cells = old_data[CNT_W-1:0] + CNT_W'(1);
      end
      new_data = {new_free, new_cells};
      product  = (CNT_W+RATIO_W)'(new_cells) * (CNT_W+RATIO_W)'(ratio_c);
      required = product[CNT_W+RATIO_W-1:16];
      blk_free = {1'b0, new_free} >= required;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_go) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_bc_ff    <= bcol_ff;
         s1_brow_ff  <= brow_ff;
         s1_first_ff <= first_cell;
         s1_free_ff  <= free_cell;
         s1_emit_ff  <= blk_x_end && blk_y_end;
         s1_last_ff  <= row_end && col_end;
         fwd_hit_ff  <= s1_valid_ff && (s1_bc_ff == bcol_ff);
         fwd_data_ff <= new_data;
      end
   end

   // output register
   assign rsp_load = s1_valid_ff && s1_emit_ff && s1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_col_ff  <= s1_bc_ff;
         rsp_row_ff  <= s1_brow_ff;
         rsp_free_ff <= blk_free;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.block_col  = rsp_col_ff;
   assign rsp_ch.block_row  = rsp_row_ff;
   assign rsp_ch.is_free    = rsp_free_ff;
   assign rsp_ch.last_block = rsp_last_ff;

   `OBD_ASSERT_IMPL(a_stall_blocks_input, clock, reset, rsp_valid_ff && !rsp_ch.ready && s1_valid_ff && s1_emit_ff, !req_ch.ready, "input taken while a completed block cannot leave")
   `OBD_ASSERT_NEXT(a_accept_fills_stage, clock, reset, accept, s1_valid_ff, "accepted item missing from stage 1")
   `OBD_ASSERT_NEXT(a_stage_holds, clock, reset, s1_valid_ff && !s1_go, s1_valid_ff && $stable(s1_bc_ff), "stalled stage 1 item lost or changed")

endmodule

`default_nettype wire

/* tb/occupancy_block_downsampler_checker.sv */
// Scoreboard for the occupancy block downsampler: tracks register writes,
// predicts one block result per completed block and compares what leaves.
// Depends on obd_pkg, obd_req_if and obd_rsp_if.
`default_nettype none

module occupancy_block_downsampler_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [obd_pkg::CFG_IDX_W-1:0]  csr_index,
   input  logic [obd_pkg::CFG_DATA_W-1:0] csr_wr_data,
   obd_req_if                             cell_mon,
   obd_rsp_if                             block_mon,
   output int                             mismatch_count,
   output int                             outstanding_blocks,
   output int                             blocks_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import obd_pkg::*;

   typedef struct packed {
      pos_type block_col;
      pos_type block_row;
      logic    is_free;
      logic    last_block;
   } block_result_type;

   block_result_type expected_blocks[$];

   logic [DIM_W-1:0]   width_reg;
   logic [DIM_W-1:0]   height_reg;
   logic [BS_W-1:0]    bs_reg;
   cell_type           thr_reg;
   logic [RATIO_W-1:0] ratio_reg;

   logic [CNT_W-1:0] free_tally [MEM_DEPTH];
   logic [CNT_W-1:0] cell_tally [MEM_DEPTH];
   pos_type          col_pos, row_pos, blk_col, blk_row;
   logic [OFS_W-1:0] x_ofs, y_ofs;

   int fail_total;
   int compare_total;

   initial begin
      fail_total    = 0;
      compare_total = 0;
   end

   // Fold one cell into its block column and queue a result when the block closes.
   task automatic absorb_cell(input cell_type v);
      int      w, h, bs, ratio, need;
      logic    free_cell, row_end, col_end, x_end, y_end;
      pos_type bc;
      w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
      h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg));
      bs = (bs_reg == 0) ? 1 : ((bs_reg > BS_MAX) ? BS_MAX : int'(bs_reg));
      ratio = (ratio_reg > RATIO_ONE) ? RATIO_ONE : int'(ratio_reg);
      free_cell = (v >= 0) && (v <= thr_reg);
      bc = blk_col;
      row_end = int'(col_pos) + 1 >= w;
      col_end = int'(row_pos) + 1 >= h;
      x_end = (int'(x_ofs) + 1 >= bs) || row_end;
      y_end = (int'(y_ofs) + 1 >= bs) || col_end;

      // top-left cell of a block overwrites the column tallies
      if (x_ofs == 0 && y_ofs == 0) begin
         free_tally[bc] = CNT_W'(free_cell);
         cell_tally[bc] = CNT_W'(1);
      end else begin
         free_tally[bc] = free_tally[bc] + CNT_W'(free_cell);
         cell_tally[bc] = cell_tally[bc] + CNT_W'(1);
      end

      if (x_end && y_end) begin
         need = (int'(cell_tally[bc]) * ratio) >>> 16;
         expected_blocks.push_back('{block_col:  bc,
                                     block_row:  blk_row,
                                     is_free:    int'(free_tally[bc]) >= need,
                                     last_block: row_end && col_end});
      end

      if (row_end) begin
         col_pos = '0;
         x_ofs   = '0;
         blk_col = '0;
         if (col_end) begin
            row_pos = '0;
            y_ofs   = '0;
            blk_row = '0;
         end else begin
            row_pos = row_pos + 1'b1;
            if (int'(y_ofs) + 1 >= bs) begin
               y_ofs   = '0;
               blk_row = blk_row + 1'b1;
            end else begin
               y_ofs = y_ofs + 1'b1;
            end
         end
      end else begin
         col_pos = col_pos + 1'b1;
         if (int'(x_ofs) + 1 >= bs) begin
            x_ofs   = '0;
            blk_col = blk_col + 1'b1;
         end else begin
            x_ofs = x_ofs + 1'b1;
         end
      end
   endtask

   always @(posedge clock) begin : track
      block_result_type got, want;
      if (reset) begin
         width_reg  = MAP_WIDTH_RST;
         height_reg = MAP_HEIGHT_RST;
         bs_reg     = BLOCK_SIZE_RST;
         thr_reg    = cell_type'(THRESHOLD_RST);
         ratio_reg  = RATIO_RST;
         col_pos    = '0;
         row_pos    = '0;
         blk_col    = '0;
         blk_row    = '0;
         x_ofs      = '0;
         y_ofs      = '0;
         expected_blocks.delete();
      end else begin
         // retire the result first: it belongs to a cell taken at an earlier edge
         if (block_mon.valid && block_mon.ready) begin
            got = '{block_col:  block_mon.block_col,
                    block_row:  block_mon.block_row,
                    is_free:    block_mon.is_free,
                    last_block: block_mon.last_block};
            compare_total++;
            if (expected_blocks.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("%0t: unexpected block result: col %0d row %0d free %0b last %0b",
                           $realtime, got.block_col, got.block_row, got.is_free,
                           got.last_block);
            end else begin
               want = expected_blocks.pop_front();
               if (got !== want) begin
                  fail_total++;
                  if (fail_total <= 10) begin
                     $write("%0t: block result differs: expected col %0d row %0d",
                            $realtime, want.block_col, want.block_row);
                     $write(" free %0b last %0b", want.is_free, want.last_block);
                     $display(", got col %0d row %0d free %0b last %0b",
                              got.block_col, got.block_row, got.is_free,
                              got.last_block);
                  end
               end
            end
         end
         if (cell_mon.valid && cell_mon.ready)
            absorb_cell(cell_mon.cell_value);
         if (csr_wr_en) begin
            case (csr_index)
               CFG_MAP_WIDTH:  width_reg  = csr_wr_data[DIM_W-1:0];
               CFG_MAP_HEIGHT: height_reg = csr_wr_data[DIM_W-1:0];
               CFG_BLOCK_SIZE: bs_reg     = csr_wr_data[BS_W-1:0];
               CFG_THRESHOLD:  thr_reg    = cell_type'(csr_wr_data[CELL_W-1:0]);
               CFG_FREE_RATIO: ratio_reg  = csr_wr_data[RATIO_W-1:0];
               default: ;
            endcase
         end
      end
      mismatch_count     <= fail_total;
      outstanding_blocks <= expected_blocks.size();
      blocks_checked     <= compare_total;
   end

endmodule

`default_nettype wire

/* tb/occupancy_block_downsampler_top_tb.sv */
// Testbench top for the occupancy block downsampler: clock, reset, cell and
// register stimulus, result back-pressure, watchdog and verdict.
// Depends on obd_pkg, the channel interfaces, the block and its checker.
`default_nettype none

module occupancy_block_downsampler_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import obd_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_CELLS = 706;
   // 5x3 map in 2x2 blocks: partial blocks on the right and bottom edges
   localparam int EDGE_CELLS [15] = '{-128, 0, 10, 11, 127,
                                      -1, 1, 9, 64, 5,
                                      0, -2, 10, 100, 0};

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CFG_IDX_W-1:0]  csr_index;
   logic [CFG_DATA_W-1:0] csr_wr_data;

   int  mismatches;
   int  outstanding;
   int  blocks_seen;
   int  cells_sent;
   int  settings_loaded;
   int  cur_thr;
   bit  quiet;

   obd_req_if cell_ch ();
   obd_rsp_if block_ch ();

   occupancy_block_downsampler_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_ch      (cell_ch),
      .rsp_ch      (block_ch)
   );

   occupancy_block_downsampler_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .cell_mon           (cell_ch),
      .block_mon          (block_ch),
      .mismatch_count     (mismatches),
      .outstanding_blocks (outstanding),
      .blocks_checked     (blocks_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short idles, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic cell_type pick_cell(input int thr, input int bias);
      int c;
      if (thr >= 0 && $urandom_range(0, 99) < bias)
         return cell_type'($urandom_range(0, thr));
      case ($urandom_range(0, 9))
         0: return cell_type'(127);
         1: return cell_type'(-128);
         2: return cell_type'(0);
         3: begin
            c = thr + int'($urandom_range(0, 2)) - 1;
            c = (c > 127) ? 127 : ((c < -128) ? -128 : c);
            return cell_type'(c);
         end
         default: return cell_type'($urandom_range(0, 255));
      endcase
   endfunction

   // random junk above the register's own bits now and then
   function automatic logic [CFG_DATA_W-1:0] with_junk(input int value, input int bits);
      logic [CFG_DATA_W-1:0] data;
      data = CFG_DATA_W'(value) & ((CFG_DATA_W'(1) << bits) - 1'b1);
      if (bits < CFG_DATA_W && $urandom_range(0, 3) == 0)
         data = data | (CFG_DATA_W'($urandom) << bits);
      return data;
   endfunction

   task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   // which: bit 0 width, 1 height, 2 block size, 3 threshold, 4 ratio
   task automatic load_regs(input int w, input int h, input int bs, input int thr,
                            input int ratio, input logic [4:0] which);
      if (which[0]) put_reg(CFG_MAP_WIDTH, with_junk(w, DIM_W));
      if (which[1]) put_reg(CFG_MAP_HEIGHT, with_junk(h, DIM_W));
      if (which[2]) put_reg(CFG_BLOCK_SIZE, with_junk(bs, BS_W));
      if (which[3]) begin
         put_reg(CFG_THRESHOLD, with_junk(thr, CELL_W));
         cur_thr = thr;
      end
      if (which[4]) put_reg(CFG_FREE_RATIO, with_junk(ratio, RATIO_W));
      // unused indexes must be ignored
      if ($urandom_range(0, 9) == 0)
         put_reg(CFG_IDX_W'($urandom_range(int'(CFG_FREE_RATIO) + 1, (1 << CFG_IDX_W) - 1)),
                 CFG_DATA_W'($urandom));
      csr_wr_en <= 1'b0;
      settings_loaded++;
   endtask

   task automatic send_cell(input cell_type v);
      int gap;
      gap = quiet ? 0 : gap_len();
      if (gap > 0) begin
         cell_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      cell_ch.valid      <= 1'b1;
      cell_ch.cell_value <= v;
      @(posedge clock);
      while (!cell_ch.ready) @(posedge clock);
      cells_sent++;
   endtask

   // hold the sender until every block result is back and the pipe is empty
   task automatic settle();
      cell_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : result_ready
      int n;
      block_ch.ready = 1'b0;
      forever begin
         n = quiet ? 0 : gap_len();
         if (n > 0) begin
            block_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         block_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (cell_ch.valid && cell_ch.ready) || (block_ch.valid && block_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("occupancy_block_downsampler_top: mismatch");
      $finish;
   end

   initial begin : stimulus
      int w, h, bs, thr, ratio, n, bias, random_cells;
      logic [4:0] which;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = '0;
      csr_wr_data        = '0;
      cell_ch.valid      = 1'b0;
      cell_ch.cell_value = '0;
      cells_sent         = 0;
      settings_loaded    = 0;
      cur_thr            = 0;
      quiet              = 1'b0;
      random_cells       = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // one full 1024-wide row so every column tally holds a written value;
      // width and ratio above range, block size of zero
      load_regs(2047, 1, 0, 127, 131071, 5'h1F);
      repeat (MAX_WIDTH) send_cell(cell_type'($urandom_range(0, 255)));
      settle();

      // partial edge blocks, threshold boundaries, value extremes
      load_regs(5, 3, 2, 10, 32768, 5'h1F);
      foreach (EDGE_CELLS[i]) send_cell(cell_type'(EDGE_CELLS[i]));
      settle();

      // nothing free, zero ratio; then shrink the map under a half-done block
      load_regs(8, 4, 4, -128, 0, 5'h1F);
      send_cell(cell_type'(0));
      send_cell(cell_type'(127));
      settle();
      load_regs(2, 1, 0, 127, RATIO_ONE, 5'b11011);
      send_cell(cell_type'(50));
      settle();

      // zero sizes and block size beyond the offset range
      load_regs(0, 0, 31, 0, 0, 5'b00111);
      send_cell(cell_type'(-128));
      send_cell(cell_type'(127));
      settle();

      while (random_cells < RANDOM_CELLS) begin
         case ($urandom_range(0, 19))
            0:       w = MAX_WIDTH;
            1:       w = $urandom_range(0, 2047);
            2, 3:    w = $urandom_range(25, 160);
            default: w = $urandom_range(1, 24);
         endcase
         case ($urandom_range(0, 19))
            0:       h = $urandom_range(MAX_HEIGHT + 1, 2047);
            1:       h = MAX_HEIGHT;
            2:       h = 0;
            default: h = $urandom_range(1, 12);
         endcase
         case ($urandom_range(0, 9))
            0:       bs = 0;
            1:       bs = $urandom_range(BS_MAX + 1, 31);
            2:       bs = BS_MAX;
            3:       bs = $urandom_range(7, BS_MAX - 1);
            default: bs = $urandom_range(1, 6);
         endcase
         case ($urandom_range(0, 9))
            0:             thr = -128;
            1:             thr = 127;
            2:             thr = -1;
            3, 4, 5, 6, 7: thr = $urandom_range(0, 60);
            default:       thr = int'($urandom_range(0, 255)) - 128;
         endcase
         case ($urandom_range(0, 9))
            0:       ratio = 0;
            1:       ratio = RATIO_ONE;
            2:       ratio = $urandom_range(RATIO_ONE + 1, (1 << RATIO_W) - 1);
            default: ratio = $urandom_range(0, RATIO_ONE);
         endcase
         which = ($urandom_range(0, 1) == 0) ? 5'h1F : 5'($urandom_range(0, 31));
         load_regs(w, h, bs, thr, ratio, which);

         quiet = ($urandom_range(0, 3) == 0);
         bias  = $urandom_range(0, 100);
         n     = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600) : $urandom_range(1, 150);
         if (n > RANDOM_CELLS - random_cells)
            n = RANDOM_CELLS - random_cells;
         repeat (n) begin
            send_cell(pick_cell(cur_thr, bias));
            if ($urandom_range(0, 199) == 0)
               settle();
         end
         random_cells += n;
         settle();
         quiet = 1'b0;
      end

      settle();
      repeat (4) @(posedge clock);
      $display("Run covered %0d cells over %0d register settings, %0d block results compared.",
               cells_sent, settings_loaded, blocks_seen);
      if (mismatches == 0 && outstanding == 0)
         $display("occupancy_block_downsampler_top: match");
      else
         $display("occupancy_block_downsampler_top: mismatch");
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/obd_pkg.sv
rtl/obd_req_if.sv
rtl/obd_rsp_if.sv
rtl/obd_ram.sv
rtl/occupancy_block_downsampler_top.sv
tb/occupancy_block_downsampler_checker.sv
tb/occupancy_block_downsampler_top_tb.sv
